// ===== sv/pltl_pkg.sv =====
// Shared codes, constants and controller/datapath interface types.
package pltl_pkg;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam int DATA_W = 16;
   localparam int NP_W   = 5;
   localparam int IDX_W  = 4;
   localparam int PROD_W = 2 * DATA_W;

   localparam logic [DATA_W-1:0] FULL_SCALE = 16'hFFFF;

   typedef enum logic [1:0] {
      ADDR_HI,
      ADDR_BELOW,
      ADDR_ZERO
   } addr_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_READ,
      RES_INTERP
   } res_sel_type;

   typedef struct packed {
      logic         ld_item;
      logic         wr_entry;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         ld_hi;
      logic         ld_lo;
      logic         dec_hi;
      logic         ld_res;
      res_sel_type  res_sel;
      logic         div_start;
      logic         ld_frac;
      logic         ld_prod;
      logic         ld_rsp;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic x_ge;
      logic x_le;
      logic hi_is_one;
      logic div_done;
   } status_type;

endpackage

// ===== sv/pltl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pltl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pltl_div.sv =====
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
module pltl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pltl_pkg::PROD_W-1:0]   dividend,
   input  logic [pltl_pkg::DATA_W-1:0]   divisor,
   output logic                          done,
   output logic [pltl_pkg::PROD_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(pltl_pkg::PROD_W);

   logic [pltl_pkg::PROD_W-1:0] quo_ff, quo_in;
   logic [pltl_pkg::DATA_W-1:0] rem_ff, rem_in;
   logic [pltl_pkg::DATA_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   logic [pltl_pkg::DATA_W:0]   rem_sh;
   logic [pltl_pkg::DATA_W:0]   rem_sub;
   logic                        fits;

   assign rem_sh  = {rem_ff, quo_ff[pltl_pkg::PROD_W-1]};
   assign fits    = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract where the divisor fits
         quo_in  = {quo_ff[pltl_pkg::PROD_W-2:0], fits};
         rem_in  = fits ? rem_sub[pltl_pkg::DATA_W-1:0] : rem_sh[pltl_pkg::DATA_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(pltl_pkg::PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/pltl_dpath.sv =====
// Datapath: count register, breakpoint RAM, segment registers, divider and multiplier.
module pltl_dpath #(
   parameter int MAX_POINTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pltl_pkg::cmd_type             cmd,
   output pltl_pkg::status_type          status,
   input  logic                          csr_write_en,
   input  logic [pltl_pkg::NP_W-1:0]     csr_num_points,
   input  logic [pltl_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [pltl_pkg::DATA_W-1:0]   req_x_value,
   input  logic [pltl_pkg::DATA_W-1:0]   req_y_value,
   output logic [pltl_pkg::DATA_W-1:0]   rsp_y_result
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int CMP_W = (CNT_W > pltl_pkg::NP_W) ? CNT_W : pltl_pkg::NP_W;
   localparam int DW    = pltl_pkg::DATA_W;
   localparam int PW    = pltl_pkg::PROD_W;

   logic [pltl_pkg::NP_W-1:0] num_points_ff;
   logic [DW-1:0]             x_ff, xhi_ff, yhi_ff, xlo_ff, ylo_ff;
   logic [DW-1:0]             res_ff, res_in, frac_ff, rsp_data_ff;
   logic [PW-1:0]             prod_ff;
   logic [AW-1:0]             hi_ff, hi_in;

   logic [CMP_W-1:0]          np_ext, max_ext, count;
   logic                      idx_ok;
   logic [AW-1:0]             rd_addr;
   logic [2*DW-1:0]           rd_data;
   logic [DW-1:0]             rd_x, rd_y;
   logic [DW-1:0]             dx, dxw, abs_dy, interp;
   logic                      y_up;
   logic [PW-1:0]             frac_num, quo;
   logic [PW-1:0]             scale_sum;
   logic [DW-1:0]             scale_q;
   logic                      div_done;

   // clamp the programmed count to the table depth
   assign np_ext  = CMP_W'(num_points_ff);
   assign max_ext = CMP_W'(MAX_POINTS);
   assign count   = (np_ext > max_ext) ? max_ext : np_ext;
   assign idx_ok  = CMP_W'(req_entry_index) < max_ext;

   always_comb begin
      unique case (cmd.addr_sel)
         pltl_pkg::ADDR_HI:    rd_addr = hi_ff;
         pltl_pkg::ADDR_BELOW: rd_addr = hi_ff - AW'(1);
         pltl_pkg::ADDR_ZERO:  rd_addr = '0;
         default:              rd_addr = hi_ff;
      endcase
   end

   pltl_ram #(
      .WIDTH (2 * DW),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_entry && idx_ok),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({req_x_value, req_y_value}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[2*DW-1:DW];
   assign rd_y = rd_data[DW-1:0];

   // segment arithmetic
   assign dx       = x_ff - xlo_ff;
   assign dxw      = xhi_ff - xlo_ff;
   assign frac_num = {dx, {DW{1'b0}}} - {{DW{1'b0}}, dx};
   assign y_up     = ylo_ff < yhi_ff;
   assign abs_dy   = y_up ? (yhi_ff - ylo_ff) : (ylo_ff - yhi_ff);

   // divide the product by full scale: floor(p / 65535) = (p + (p >> 16) + 1) >> 16,
   // exact while the quotient fits 16 bits, and the sum cannot overflow 32 bits
   assign scale_sum = prod_ff + {{DW{1'b0}}, prod_ff[PW-1:DW]} + {{(PW-1){1'b0}}, 1'b1};
   assign scale_q   = scale_sum[PW-1:DW];
   assign interp    = y_up ? (ylo_ff + scale_q) : (ylo_ff - scale_q);

   pltl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (frac_num),
      .divisor  (dxw),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      hi_in = hi_ff;
      if (cmd.ld_item) begin
         hi_in = AW'(count - CMP_W'(1));
      end else if (cmd.dec_hi) begin
         hi_in = hi_ff - AW'(1);
      end
   end

   always_comb begin
      unique case (cmd.res_sel)
         pltl_pkg::RES_ZERO:   res_in = '0;
         pltl_pkg::RES_READ:   res_in = rd_y;
         pltl_pkg::RES_INTERP: res_in = interp;
         default:              res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= '0;
      end else if (csr_write_en) begin
         num_points_ff <= csr_num_points;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      if (cmd.ld_item) begin
         x_ff <= req_x_value;
      end
      if (cmd.ld_hi) begin
         xhi_ff <= rd_x;
         yhi_ff <= rd_y;
      end
      if (cmd.ld_lo) begin
         xlo_ff <= rd_x;
         ylo_ff <= rd_y;
      end
      if (cmd.ld_frac) begin
         frac_ff <= quo[DW-1:0] + DW'(1);
      end
      if (cmd.ld_prod) begin
         prod_ff <= {{DW{1'b0}}, frac_ff} * {{DW{1'b0}}, abs_dy};
      end
      if (cmd.ld_res) begin
         res_ff <= res_in;
      end
      if (cmd.ld_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign status.count_zero = (count == '0);
   assign status.x_ge       = x_ff >= rd_x;
   assign status.x_le       = x_ff <= rd_x;
   assign status.hi_is_one  = (hi_ff == AW'(1));
   assign status.div_done   = div_done;

   assign rsp_y_result = rsp_data_ff;

endmodule

// ===== sv/pltl_ctrl.sv =====
// Controller: sequences table reads, segment search, divisions and the result hand-off.
module pltl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pltl_pkg::status_type status,
   output pltl_pkg::cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE       = 12'b000000000001,
      S_RD_TOP     = 12'b000000000010,
      S_CK_TOP     = 12'b000000000100,
      S_RD_BOT     = 12'b000000001000,
      S_CK_BOT     = 12'b000000010000,
      S_RD_SRCH    = 12'b000000100000,
      S_CK_SRCH    = 12'b000001000000,
      S_FRAC_GO    = 12'b000010000000,
      S_FRAC_WAIT  = 12'b000100000000,
      S_MUL        = 12'b001000000000,
      S_SCALE      = 12'b010000000000,
      S_RESULT     = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == pltl_pkg::OP_LOOKUP) begin
                  cmd.ld_item = 1'b1;
                  if (status.count_zero) begin
                     cmd.ld_res  = 1'b1;
                     cmd.res_sel = pltl_pkg::RES_ZERO;
                     state_in    = S_RESULT;
                  end else begin
                     state_in = S_RD_TOP;
                  end
               end else begin
                  cmd.wr_entry = 1'b1;
               end
            end
         end
         S_RD_TOP: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = pltl_pkg::ADDR_HI;
            state_in     = S_CK_TOP;
         end
         S_CK_TOP: begin
            if (status.x_ge) begin
               cmd.ld_res  = 1'b1;
               cmd.res_sel = pltl_pkg::RES_READ;
               state_in    = S_RESULT;
            end else begin
               cmd.ld_hi = 1'b1;
               state_in  = S_RD_BOT;
            end
         end
         S_RD_BOT: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = pltl_pkg::ADDR_ZERO;
            state_in     = S_CK_BOT;
         end
         S_CK_BOT: begin
            if (status.x_le) begin
               cmd.ld_res  = 1'b1;
               cmd.res_sel = pltl_pkg::RES_READ;
               state_in    = S_RESULT;
            end else begin
               // entry 0 is the low end unless the search stops higher
               cmd.ld_lo = 1'b1;
               state_in  = S_RD_SRCH;
            end
         end
         S_RD_SRCH: begin
            if (status.hi_is_one) begin
               state_in = S_FRAC_GO;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = pltl_pkg::ADDR_BELOW;
               state_in     = S_CK_SRCH;
            end
         end
         S_CK_SRCH: begin
            if (status.x_ge) begin
               cmd.ld_lo = 1'b1;
               state_in  = S_FRAC_GO;
            end else begin
               cmd.ld_hi  = 1'b1;
               cmd.dec_hi = 1'b1;
               state_in   = S_RD_SRCH;
            end
         end
         S_FRAC_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_FRAC_WAIT;
         end
         S_FRAC_WAIT: begin
            if (status.div_done) begin
               cmd.ld_frac = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.ld_prod = 1'b1;
            state_in    = S_SCALE;
         end
         S_SCALE: begin
            cmd.ld_res  = 1'b1;
            cmd.res_sel = pltl_pkg::RES_INTERP;
            state_in    = S_RESULT;
         end
         S_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.ld_rsp = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.ld_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/piecewise_linear_table_lookup_top.sv =====
// Top level of the piecewise-linear table lookup block.
//
// Usage: the req channel carries one item per handshake. A write item (req_op low)
// stores req_x_value / req_y_value at table entry req_entry_index in the accept
// cycle and returns nothing; entries at or beyond MAX_POINTS are dropped. A lookup
// item (req_op high) returns one item on the rsp channel holding y_result.
// csr_write_en / csr_num_points set the number of breakpoints in use; write it
// only while no lookup is in flight.
//
// Sequencing: a write leaves the block ready again at once. A lookup on an empty
// table goes straight to the result; otherwise it reads and compares the top entry
// (clamp at the top end), then entry 0 (clamp at the bottom end), then searches down
// from the top for the segment. Each search step reads one entry and compares it the
// next cycle, the fraction comes from a 32-step restoring divider, and the scale by
// full scale is a shift-and-add. One lookup is processed at a time; req_ready is high
// only while idle.
//
// Stalls: the result sits in an output register, so a new item is accepted while
// rsp_valid waits on rsp_ready; a following lookup holds in its last state until
// that register is free. Reset clears the count to zero; table contents are
// undefined until written.
module piecewise_linear_table_lookup_top #(
   parameter int MAX_POINTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [pltl_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [pltl_pkg::DATA_W-1:0]   req_x_value,
   input  logic [pltl_pkg::DATA_W-1:0]   req_y_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pltl_pkg::DATA_W-1:0]   rsp_y_result,
   input  logic                          csr_write_en,
   input  logic [pltl_pkg::NP_W-1:0]     csr_num_points
);

   pltl_pkg::cmd_type    cmd;
   pltl_pkg::status_type status;

   // sequencing of the search, the division and the scaling
   pltl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table storage and arithmetic
   pltl_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write_en    (csr_write_en),
      .csr_num_points  (csr_num_points),
      .req_entry_index (req_entry_index),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .rsp_y_result    (rsp_y_result)
   );

   // out of reset the block is idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

   // a write item never makes the block busy
   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == pltl_pkg::OP_WRITE) |=> req_ready)
      else $error("write item left the block busy");

   // a lookup item holds off further items for at least the next cycle
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == pltl_pkg::OP_LOOKUP) |=> !req_ready)
      else $error("lookup item did not occupy the block");

   // a new result only appears as the controller hands over and returns to idle
   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid ##1 rsp_valid) |-> req_ready)
      else $error("result raised without the block returning to idle");

endmodule

// ===== tb/piecewise_linear_table_lookup_top_test.sv =====
// Self-checking testbench for the piecewise-linear table lookup block.
`timescale 1ns / 1ps

module piecewise_linear_table_lookup_top_test;

   localparam int DATA_W = pltl_pkg::DATA_W;
   localparam int NP_W   = pltl_pkg::NP_W;
   localparam int IDX_W  = pltl_pkg::IDX_W;
   localparam int PROD_W = pltl_pkg::PROD_W;
   localparam logic [DATA_W-1:0] FULL_SCALE = pltl_pkg::FULL_SCALE;

   localparam int MAX_POINTS   = 16;
   localparam int TOTAL_ITEMS  = 1100;
   localparam int CALM_ITEMS   = 150;   // closing stretch run with no idling on either side
   localparam int DRAIN_CYCLES = 8;     // let the last write settle; leave a margin before the CSR
   localparam int TAIL_CYCLES  = 120;   // margin for the longest lookup to finish

   typedef enum logic [1:0] {
      ROW_COUNT,
      ROW_WRITE,
      ROW_LOOKUP
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [NP_W-1:0]   count;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic              known;
      logic [DATA_W-1:0] known_y;
   } stim_row_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_op         = pltl_pkg::OP_WRITE;
   logic [IDX_W-1:0]    req_entry_index = '0;
   logic [DATA_W-1:0]   req_x_value    = '0;
   logic [DATA_W-1:0]   req_y_value    = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [DATA_W-1:0]   rsp_y_result;
   logic                csr_write_en   = 1'b0;
   logic [NP_W-1:0]     csr_num_points = '0;

   // Shadow of the block: breakpoint table and the count in use.
   logic [DATA_W-1:0]   x_points [MAX_POINTS];
   logic [DATA_W-1:0]   y_points [MAX_POINTS];
   logic [NP_W-1:0]     point_count = '0;
   bit                  table_full  = 1'b0;

   // Lookup results still owed by the block, oldest first.
   logic [DATA_W-1:0]   expected_y [$];
   logic [DATA_W-1:0]   wanted_y;

   int unsigned         items_sent = 0;
   int unsigned         fail_count = 0;
   int unsigned         stall_left = 0;
   bit                  send_idle  = 1'b1;
   bit                  take_idle  = 1'b1;

   // Directed opening: empty table, clamps at both ends, every segment slope,
   // a single point, an unordered table, and counts at and beyond the table size.
   // Table used: (0010,1234) (1000,FFFF) (8000,0000) (FFF0,0000), entry 15 (FFFF,FFFF).
   stim_row_type directed_rows [27] = '{
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h0000, 16'hFFFF, 1'b1, 16'h0000}, // empty table
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'hFFFF, 16'h0000, 1'b1, 16'h0000},
      '{ROW_WRITE,  5'd0,  4'd0,  16'h0010, 16'h1234, 1'b0, 16'h0000},
      '{ROW_WRITE,  5'd0,  4'd1,  16'h1000, 16'hFFFF, 1'b0, 16'h0000},
      '{ROW_WRITE,  5'd0,  4'd2,  16'h8000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_WRITE,  5'd0,  4'd3,  16'hFFF0, 16'h0000, 1'b0, 16'h0000},
      '{ROW_WRITE,  5'd0,  4'd15, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
      '{ROW_COUNT,  5'd1,  4'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000}, // single point
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'hFFFF, 16'h5A5A, 1'b1, 16'h1234},
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h0000, 16'hA5A5, 1'b1, 16'h1234},
      '{ROW_COUNT,  5'd4,  4'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h0000, 16'h0000, 1'b1, 16'h1234}, // below first x
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h0010, 16'h0000, 1'b1, 16'h1234}, // at first x
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'hFFF0, 16'h0000, 1'b1, 16'h0000}, // at last x
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'hFFFF, 16'h0000, 1'b1, 16'h0000}, // above last x
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h0011, 16'h0000, 1'b0, 16'h0000}, // just above xlo
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h0800, 16'h0000, 1'b0, 16'h0000}, // rising
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h0FFF, 16'h0000, 1'b0, 16'h0000}, // just below xhi
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h4000, 16'h0000, 1'b0, 16'h0000}, // falling
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h9000, 16'h0000, 1'b0, 16'h0000}, // flat
      '{ROW_WRITE,  5'd0,  4'd2,  16'h0800, 16'h0000, 1'b0, 16'h0000}, // break the order
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h0C00, 16'h0000, 1'b0, 16'h0000},
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'h0400, 16'h0000, 1'b0, 16'h0000}, // search steps down
      '{ROW_COUNT,  5'd16, 4'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000}, // full table
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'hFFFF, 16'h0000, 1'b1, 16'hFFFF},
      '{ROW_COUNT,  5'd31, 4'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000}, // count past the table
      '{ROW_LOOKUP, 5'd0,  4'd0,  16'hFFFF, 16'h0000, 1'b1, 16'hFFFF}
   };

   piecewise_linear_table_lookup_top #(
      .MAX_POINTS(MAX_POINTS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_entry_index (req_entry_index),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_y_result    (rsp_y_result),
      .csr_write_en    (csr_write_en),
      .csr_num_points  (csr_num_points)
   );

   always #1 clock = ~clock;

   // Interpolate (or clamp) y for x against the shadow table.
   function automatic logic [DATA_W-1:0] interpolate_y(input logic [DATA_W-1:0] x);
      int unsigned       used;
      int unsigned       seg;
      logic [PROD_W-1:0] x_lo, x_hi, y_lo, y_hi, frac;
      used = (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
      if (used == 0)
         return '0;
      seg = used - 1;
      if (x >= x_points[seg])
         return y_points[seg];
      if (x <= x_points[0])
         return y_points[0];
      // Walk down from the top; stops at the first entry whose lower neighbour is <= x.
      while (seg > 1 && x_points[seg - 1] > x)
         seg--;
      x_lo = PROD_W'(x_points[seg - 1]);
      x_hi = PROD_W'(x_points[seg]);
      y_lo = PROD_W'(y_points[seg - 1]);
      y_hi = PROD_W'(y_points[seg]);
      frac = (PROD_W'(FULL_SCALE) * (PROD_W'(x) - x_lo)) / (x_hi - x_lo) + 1;
      if (y_lo < y_hi)
         return DATA_W'(frac * (y_hi - y_lo) / PROD_W'(FULL_SCALE) + y_lo);
      return DATA_W'(y_lo - frac * (y_lo - y_hi) / PROD_W'(FULL_SCALE));
   endfunction

   // Pick a lookup x: ends of the range, on a breakpoint, beside one, inside a segment, or at random.
   function automatic logic [DATA_W-1:0] pick_lookup_x();
      int unsigned       used;
      int unsigned       i;
      logic [DATA_W-1:0] lo, hi;
      used = (point_count > MAX_POINTS || point_count == 0) ? MAX_POINTS : point_count;
      i    = $urandom_range(0, used - 1);
      lo   = x_points[i];
      hi   = x_points[(i + 1 < used) ? i + 1 : i];
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 1) ? FULL_SCALE : '0;
         1: return lo;
         2: begin
            if ($urandom_range(0, 1))
               return lo + DATA_W'($urandom_range(1, 3));
            return lo - DATA_W'($urandom_range(1, 3));
         end
         3, 4: return (hi > lo) ? lo + DATA_W'($urandom_range(0, hi - lo)) : lo;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Offer one item and hold it until accepted; update the shadow on acceptance.
   task automatic send_item(input logic op, input logic [IDX_W-1:0] index,
                            input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                            input logic known, input logic [DATA_W-1:0] known_y);
      if (send_idle && items_sent < TOTAL_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_entry_index <= index;
      req_x_value     <= x;
      req_y_value     <= y;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (op == pltl_pkg::OP_WRITE) begin
         x_points[index] = x;
         y_points[index] = y;
      end else begin
         expected_y.push_back(known ? known_y : interpolate_y(x));
      end
      items_sent++;
   endtask

   // Drop valid, wait for every owed result, then let the last write settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_y.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_point_count(input logic [NP_W-1:0] count);
      csr_write_en   <= 1'b1;
      csr_num_points <= count;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      point_count     = count;
   endtask

   // Write n entries from 0 upwards. Style 0 scatters x at random; style 1 packs the
   // breakpoints closely (tiny divisors); style 2 spans the whole range; others ascend.
   task automatic fill_table(input int unsigned style, input int unsigned n);
      int unsigned       i;
      int unsigned       step_max;
      logic [DATA_W-1:0] xv, yv;
      xv = (style == 2) ? '0 : DATA_W'($urandom_range(0, 16383));
      yv = DATA_W'($urandom);
      for (i = 0; i < n; i++) begin
         if (style == 0) begin
            xv = DATA_W'($urandom);
         end else if (i != 0) begin
            step_max = (style == 1) ? 4 : (65535 - xv) * 2 / (n - i);
            if (step_max > 65535 - xv)
               step_max = 65535 - xv;
            xv = xv + DATA_W'($urandom_range(0, step_max));
         end
         if (style == 2 && i == n - 1)
            xv = FULL_SCALE;
         // Now and then repeat the previous y to get a flat segment.
         if ($urandom_range(0, 7) != 0)
            yv = DATA_W'($urandom);
         send_item(pltl_pkg::OP_WRITE, IDX_W'(i), xv, yv, 1'b0, '0);
      end
   endtask

   // One phase: new count, fresh table contents, then a burst of lookups with stray writes.
   task automatic run_phase();
      int unsigned     used;
      int unsigned     n_lookups;
      logic [NP_W-1:0] count;
      drain_results();
      send_idle = $urandom_range(0, 3) != 0;
      take_idle = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
         0:       count = 5'd0;
         1:       count = 5'd1;
         2:       count = 5'd2;
         3:       count = 5'd16;
         4:       count = NP_W'($urandom_range(17, 31));
         default: count = NP_W'($urandom_range(3, 15));
      endcase
      load_point_count(count);
      used = (count > MAX_POINTS) ? MAX_POINTS : count;
      // Fill the whole table once so that no later lookup can touch a stale entry.
      fill_table($urandom_range(0, 5), table_full ? used : MAX_POINTS);
      table_full = 1'b1;
      n_lookups  = $urandom_range(20, 45);
      repeat (n_lookups) begin
         if ($urandom_range(0, 11) == 0)
            send_item(pltl_pkg::OP_WRITE, IDX_W'($urandom), DATA_W'($urandom),
                      DATA_W'($urandom), 1'b0, '0);
         else
            send_item(pltl_pkg::OP_LOOKUP, IDX_W'($urandom), pick_lookup_x(),
                      DATA_W'($urandom), 1'b0, '0);
      end
   endtask

   // Result side: check each accepted item against the oldest expectation, and
   // stall rsp_ready in short random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_y.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual y_result %h",
                        $time, rsp_y_result);
               fail_count++;
            end else begin
               wanted_y = expected_y.pop_front();
               if (rsp_y_result !== wanted_y) begin
                  $display("%0t: y_result mismatch: expected %h, actual %h",
                           $time, wanted_y, rsp_y_result);
                  fail_count++;
               end
            end
         end
         if (stall_left == 0 && take_idle && items_sent < TOTAL_ITEMS - CALM_ITEMS &&
             $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 3);
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; count rows are only applied once the block is idle.
      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_COUNT: begin
               drain_results();
               load_point_count(directed_rows[r].count);
            end
            ROW_WRITE: begin
               send_item(pltl_pkg::OP_WRITE, directed_rows[r].index, directed_rows[r].x,
                         directed_rows[r].y, 1'b0, '0);
            end
            default: begin
               send_item(pltl_pkg::OP_LOOKUP, directed_rows[r].index, directed_rows[r].x,
                         directed_rows[r].y, directed_rows[r].known,
                         directed_rows[r].known_y);
            end
         endcase
      end

      while (items_sent < TOTAL_ITEMS)
         run_phase();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_y.size() == 0)
         $display("** piecewise_linear_table_lookup_top: PASSED **");
      else
         $display("** piecewise_linear_table_lookup_top: FAILED **");
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #1_200_000;
      $display("** piecewise_linear_table_lookup_top: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
sv/pltl_pkg.sv
sv/pltl_ram.sv
sv/pltl_div.sv
sv/pltl_dpath.sv
sv/pltl_ctrl.sv
sv/piecewise_linear_table_lookup_top.sv
tb/piecewise_linear_table_lookup_top_test.sv
